// File: hdl/assert_macros.svh
// Assertion macros for the marquee scroller RTL, included by lms_ctrl.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LMS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/lms_pkg.sv
// Package for the LED text marquee scroller: opcodes, register indexes,
// constants and the stage-one word passed from control to output.
// No dependencies.
package lms_pkg;

    localparam int TEXT_CAPACITY_DEF = 63;
    localparam int WINDOW_W          = 4;
    localparam int CHAR_W            = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 32;
    localparam int ELAPSED_W         = 32;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_TICK   = 3'd4
    } t_opcode;

    typedef enum logic {
        ACT_SHOW  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 2'd2;

    typedef struct packed {
        logic                         valid;
        t_action                      action;
        logic [WINDOW_W-1:0][1:0]     sel;
        logic [WINDOW_W-1:0]          inr;
        logic [CHAR_W-1:0]            color;
    } t_meta;

endpackage

// File: hdl/lms_bank.sv
// One text bank: holds every fourth character of the stored text.
// Single write port, single registered read port. No dependencies.
module lms_bank #(
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [lms_pkg::CHAR_W-1:0]                    i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [lms_pkg::CHAR_W-1:0]                    o_rd_data
);

    logic [lms_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [lms_pkg::CHAR_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: hdl/lms_ctrl.sv
// Scroller control: config registers, text length, window offset, tick
// counter, bank write/read issue and the stage-one register. Uses lms_pkg.
module lms_ctrl #(
    parameter int CAP = lms_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [2:0]                              i_opcode,
    input  logic [lms_pkg::CHAR_W-1:0]              i_char_code,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [lms_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [lms_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                                    i_take,
    output logic [lms_pkg::WINDOW_W-1:0]            o_wr_en,
    output logic [(((CAP+3)/4 > 1) ? $clog2((CAP+3)/4) : 1)-1:0] o_wr_row,
    output logic [lms_pkg::CHAR_W-1:0]              o_wr_data,
    output logic                                    o_rd_en,
    output logic [lms_pkg::WINDOW_W-1:0][(((CAP+3)/4 > 1) ? $clog2((CAP+3)/4) : 1)-1:0] o_rd_row,
    output lms_pkg::t_meta                          o_meta
);

    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(CAP + 1);
    localparam int OFF_W = LEN_W + 1;
    localparam int POS_W = LEN_W + 2;
    localparam int ROWS  = (CAP + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic signed [POS_W-1:0] NEG_WIN = POS_W'(-lms_pkg::WINDOW_W);
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);

    logic [lms_pkg::CHAR_W-1:0]    r_color;
    logic [lms_pkg::ELAPSED_W-1:0] r_interval;
    logic                          r_dir;
    logic [LEN_W-1:0]              r_len,     n_len;
    logic signed [OFF_W-1:0]       r_off,     n_off;
    logic [lms_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic                          r_scroll,  n_scroll;
    lms_pkg::t_meta                r_s1,      n_s1;

    lms_pkg::t_opcode              op;
    logic                          advance;
    logic                          accept;
    logic                          frame;
    logic                          stop;
    logic [lms_pkg::ELAPSED_W-1:0] inc;
    logic signed [POS_W-1:0]       off_ext;
    logic signed [POS_W-1:0]       len_ext;
    logic signed [POS_W-1:0]       fwd;
    logic signed [POS_W-1:0]       bwd;
    logic signed [OFF_W-1:0]       moved;
    logic signed [POS_W-1:0]       pos_b [lms_pkg::WINDOW_W];
    logic [lms_pkg::WINDOW_W-1:0]  inr_b;
    logic [1:0]                    delta;
    logic [LEN_W-1:0]              pos_u;

    assign op          = lms_pkg::t_opcode'(i_opcode);
    assign advance     = !r_s1.valid || i_take;
    assign accept      = i_in_valid && advance;
    assign o_in_stall  = !advance;
    assign o_cfg_ready = 1'b1;
    assign off_ext     = POS_W'(r_off);
    assign len_ext     = $signed({2'b00, r_len});
    assign fwd         = off_ext + POS_W'(1);
    assign bwd         = off_ext - POS_W'(1);
    assign inc         = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        if (!r_dir) begin
            moved = (fwd > len_ext) ? OFF_W'(NEG_WIN) : OFF_W'(fwd);
        end else begin
            moved = (bwd < NEG_WIN) ? OFF_W'(len_ext) : OFF_W'(bwd);
        end
    end

    // bank b sees the one window position congruent to b mod 4
    always_comb begin
        o_rd_row = '0;
        for (int b = 0; b < lms_pkg::WINDOW_W; b++) begin
            delta    = 2'(b) - r_off[1:0];
            pos_b[b] = off_ext + $signed({{(POS_W-2){1'b0}}, delta});
            inr_b[b] = (pos_b[b] >= 0) && (pos_b[b] < len_ext);
            pos_u    = LEN_W'(pos_b[b]);
            if (inr_b[b]) begin
                o_rd_row[b] = ROW_W'(pos_u[LEN_W-1:2]);
            end
        end
    end

    always_comb begin
        n_len     = r_len;
        n_off     = r_off;
        n_elapsed = r_elapsed;
        n_scroll  = r_scroll;
        frame     = 1'b0;
        stop      = 1'b0;
        o_wr_en   = '0;
        if (accept) begin
            case (op)
                lms_pkg::OP_CLEAR: begin
                    n_len = '0;
                end
                lms_pkg::OP_APPEND: begin
                    if (r_len < CAP_LEN) begin
                        n_len = r_len + 1'b1;
                        o_wr_en[r_len[1:0]] = 1'b1;
                    end
                end
                lms_pkg::OP_START: begin
                    n_off     = r_dir ? OFF_W'(len_ext) : OFF_W'(NEG_WIN);
                    n_elapsed = '0;
                    n_scroll  = 1'b1;
                end
                lms_pkg::OP_STOP: begin
                    n_scroll = 1'b0;
                    stop     = 1'b1;
                end
                lms_pkg::OP_TICK: begin
                    if (r_scroll) begin
                        if (inc >= r_interval) begin
                            frame     = 1'b1;
                            n_elapsed = '0;
                            n_off     = moved;
                        end else begin
                            n_elapsed = inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_row  = ROW_W'(r_len[LEN_W-1:2]);
    assign o_wr_data = i_char_code;
    assign o_rd_en   = advance;

    always_comb begin
        n_s1        = r_s1;
        if (advance) begin
            n_s1.valid  = frame || stop;
            n_s1.action = stop ? lms_pkg::ACT_CLEAR : lms_pkg::ACT_SHOW;
            n_s1.color  = r_color;
            for (int i = 0; i < lms_pkg::WINDOW_W; i++) begin
                n_s1.sel[i] = r_off[1:0] + 2'(i);
                n_s1.inr[i] = inr_b[n_s1.sel[i]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color    <= '0;
            r_interval <= '0;
            r_dir      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lms_pkg::CFG_COLOR:     r_color    <= i_cfg_data[lms_pkg::CHAR_W-1:0];
                lms_pkg::CFG_INTERVAL:  r_interval <= i_cfg_data;
                lms_pkg::CFG_DIRECTION: r_dir      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_off     <= '0;
            r_elapsed <= '0;
            r_scroll  <= 1'b0;
            r_s1      <= '0;
        end else begin
            r_len     <= n_len;
            r_off     <= n_off;
            r_elapsed <= n_elapsed;
            r_scroll  <= n_scroll;
            r_s1      <= n_s1;
        end
    end

    assign o_meta = r_s1;

    `LMS_ASSERT(a_len_cap, i_clk, i_rst_n, r_len <= CAP_LEN, "text length past capacity")
    `LMS_ASSERT(a_stall_busy, i_clk, i_rst_n, !o_in_stall || r_s1.valid, "stall with empty stage")
    `LMS_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1.valid && !i_take, $stable(r_s1), "stage one word lost")
    `LMS_ASSERT_NEXT(a_idle_count, i_clk, i_rst_n, !r_scroll && !(accept && op == lms_pkg::OP_START), $stable(r_elapsed), "counter moved while stopped")

endmodule

// File: hdl/lms_out.sv
// Output stage: builds the frame from bank read data and the stage-one word,
// holds it in the result register under stall. Uses lms_pkg.
module lms_out (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  lms_pkg::t_meta                                   i_meta,
    input  logic [lms_pkg::WINDOW_W-1:0][lms_pkg::CHAR_W-1:0] i_rd_data,
    input  logic                                             i_out_stall,
    output logic                                             o_take,
    output logic                                             o_out_valid,
    output logic                                             o_action,
    output logic [lms_pkg::CHAR_W-1:0]                       o_char_first,
    output logic [lms_pkg::CHAR_W-1:0]                       o_char_second,
    output logic [lms_pkg::CHAR_W-1:0]                       o_char_third,
    output logic [lms_pkg::CHAR_W-1:0]                       o_char_fourth,
    output logic [lms_pkg::CHAR_W-1:0]                       o_frame_color
);

    logic                                              r_valid;
    logic                                              r_action;
    logic [lms_pkg::WINDOW_W-1:0][lms_pkg::CHAR_W-1:0] r_chars, n_chars;
    logic [lms_pkg::CHAR_W-1:0]                        r_color, n_color;

    assign o_take = !r_valid || !i_out_stall;

    always_comb begin
        n_chars = '0;
        n_color = '0;
        if (i_meta.action == lms_pkg::ACT_SHOW) begin
            n_color = i_meta.color;
            for (int i = 0; i < lms_pkg::WINDOW_W; i++) begin
                n_chars[i] = i_meta.inr[i] ? i_rd_data[i_meta.sel[i]] : lms_pkg::SPACE_CODE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_action <= i_meta.action;
            r_chars  <= n_chars;
            r_color  <= n_color;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_action      = r_action;
    assign o_char_first  = r_chars[0];
    assign o_char_second = r_chars[1];
    assign o_char_third  = r_chars[2];
    assign o_char_fourth = r_chars[3];
    assign o_frame_color = r_color;

endmodule

// File: hdl/led_text_marquee_scroller_top.sv
// Channel  Handshake                   Word
// input    i_in_valid / o_in_stall     i_opcode, i_char_code
// result   o_out_valid / i_out_stall   o_action, o_char_*, o_frame_color
// config   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
// One word accepted per cycle while o_in_stall is low; a word's result passes through
// the stage-one register and the registered bank read, then the result register.
// Synchronous active-low reset clears control state; text store is not cleared.
// Result stall backs up through stage one into o_in_stall; config always ready.
// Top level of the LED text marquee scroller. Uses lms_pkg, lms_ctrl,
// lms_bank and lms_out.
module led_text_marquee_scroller_top #(
    parameter int TEXT_CAPACITY = lms_pkg::TEXT_CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_opcode,
    input  logic [lms_pkg::CHAR_W-1:0]          i_char_code,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_action,
    output logic [lms_pkg::CHAR_W-1:0]          o_char_first,
    output logic [lms_pkg::CHAR_W-1:0]          o_char_second,
    output logic [lms_pkg::CHAR_W-1:0]          o_char_third,
    output logic [lms_pkg::CHAR_W-1:0]          o_char_fourth,
    output logic [lms_pkg::CHAR_W-1:0]          o_frame_color,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lms_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lms_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ROWS  = (TEXT_CAPACITY + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic                                              w_take;
    logic [lms_pkg::WINDOW_W-1:0]                      w_wr_en;
    logic [ROW_W-1:0]                                  w_wr_row;
    logic [lms_pkg::CHAR_W-1:0]                        w_wr_data;
    logic                                              w_rd_en;
    logic [lms_pkg::WINDOW_W-1:0][ROW_W-1:0]           w_rd_row;
    logic [lms_pkg::WINDOW_W-1:0][lms_pkg::CHAR_W-1:0] w_rd_data;
    lms_pkg::t_meta                                    w_meta;

    lms_ctrl #(
        .CAP (TEXT_CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .o_wr_en     (w_wr_en),
        .o_wr_row    (w_wr_row),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_row    (w_rd_row),
        .o_meta      (w_meta)
    );

    for (genvar g = 0; g < lms_pkg::WINDOW_W; g++) begin : g_bank
        lms_bank #(
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (w_wr_en[g]),
            .i_wr_addr (w_wr_row),
            .i_wr_data (w_wr_data),
            .i_rd_en   (w_rd_en),
            .i_rd_addr (w_rd_row[g]),
            .o_rd_data (w_rd_data[g])
        );
    end

    lms_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_meta        (w_meta),
        .i_rd_data     (w_rd_data),
        .i_out_stall   (i_out_stall),
        .o_take        (w_take),
        .o_out_valid   (o_out_valid),
        .o_action      (o_action),
        .o_char_first  (o_char_first),
        .o_char_second (o_char_second),
        .o_char_third  (o_char_third),
        .o_char_fourth (o_char_fourth),
        .o_frame_color (o_frame_color)
    );

endmodule

// File: tb/sv/tb_led_text_marquee_scroller_top.sv
// Self-checking testbench for led_text_marquee_scroller_top: directed and random input words,
// register changes between phases, random idling on both channels.
// Depends on lms_pkg and the scroller RTL; predicts every result word and checks it in order.
module tb_led_text_marquee_scroller_top;

    localparam int                              TEXT_CAP     = lms_pkg::TEXT_CAPACITY_DEF;
    localparam int                              PIPE_DRAIN   = 4;
    localparam int                              RANDOM_WORDS = 450;
    localparam logic [2:0]                      OP_SPARE_LO  = 3'd5;
    localparam logic [2:0]                      OP_SPARE_HI  = 3'd7;
    localparam logic [lms_pkg::CFG_INDEX_W-1:0] CFG_SPARE    = 2'd3;
    localparam logic [lms_pkg::CFG_DATA_W-1:0]  INTERVAL_MAX = '1;

    typedef struct packed {
        logic                                              action;
        logic [lms_pkg::WINDOW_W-1:0][lms_pkg::CHAR_W-1:0] glyphs;
        logic [lms_pkg::CHAR_W-1:0]                        color;
    } t_frame;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [2:0]                      i_opcode = lms_pkg::OP_CLEAR;
    logic [lms_pkg::CHAR_W-1:0]      i_char_code = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_action;
    logic [lms_pkg::CHAR_W-1:0]      o_char_first;
    logic [lms_pkg::CHAR_W-1:0]      o_char_second;
    logic [lms_pkg::CHAR_W-1:0]      o_char_third;
    logic [lms_pkg::CHAR_W-1:0]      o_char_fourth;
    logic [lms_pkg::CHAR_W-1:0]      o_frame_color;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [lms_pkg::CFG_INDEX_W-1:0] i_cfg_index = lms_pkg::CFG_COLOR;
    logic [lms_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predicted scroller state
    logic [lms_pkg::CHAR_W-1:0]      text_mem [TEXT_CAP];
    int                              text_len = 0;
    int                              win_pos = 0;
    logic [lms_pkg::ELAPSED_W-1:0]   elapsed = '0;
    logic                            running = 1'b0;
    logic [lms_pkg::CHAR_W-1:0]      color_reg = '0;
    logic [lms_pkg::CFG_DATA_W-1:0]  interval_reg = '0;
    logic                            dir_reg = 1'b0;

    t_frame                          frames_due [$];
    int                              mismatches = 0;
    int                              words_sent = 0;
    int                              frames_checked = 0;
    int                              reg_writes = 0;
    logic                            quiet = 1'b0;

    led_text_marquee_scroller_top dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void advance_marquee(logic [2:0] op, logic [lms_pkg::CHAR_W-1:0] ch);
        t_frame f;
        int     pos;
        f = '0;
        case (op)
            lms_pkg::OP_CLEAR: text_len = 0;
            lms_pkg::OP_APPEND: if (text_len < TEXT_CAP) begin
                text_mem[text_len] = ch;
                text_len++;
            end
            lms_pkg::OP_START: begin
                win_pos = dir_reg ? text_len : -lms_pkg::WINDOW_W;
                elapsed = '0;
                running = 1'b1;
            end
            lms_pkg::OP_STOP: begin
                running = 1'b0;
                f.action = lms_pkg::ACT_CLEAR;
                frames_due.push_back(f);
            end
            lms_pkg::OP_TICK: if (running) begin
                if (elapsed != '1)
                    elapsed++;
                if (elapsed >= interval_reg) begin
                    elapsed = '0;
                    f.action = lms_pkg::ACT_SHOW;
                    f.color = color_reg;
                    for (int k = 0; k < lms_pkg::WINDOW_W; k++) begin
                        pos = win_pos + k;
                        f.glyphs[k] = (pos >= 0 && pos < text_len) ? text_mem[pos]
                                                                   : lms_pkg::SPACE_CODE;
                    end
                    frames_due.push_back(f);
                    if (!dir_reg) begin
                        win_pos++;
                        if (win_pos > text_len)
                            win_pos = -lms_pkg::WINDOW_W;
                    end else begin
                        win_pos--;
                        if (win_pos < -lms_pkg::WINDOW_W)
                            win_pos = text_len;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void set_model_reg(logic [lms_pkg::CFG_INDEX_W-1:0] idx,
                                          logic [lms_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lms_pkg::CFG_COLOR:     color_reg = data[lms_pkg::CHAR_W-1:0];
            lms_pkg::CFG_INTERVAL:  interval_reg = data;
            lms_pkg::CFG_DIRECTION: dir_reg = data[0];
            default: ;
        endcase
    endfunction

    function automatic logic [2:0] scroll_op();
        int unsigned r = $urandom_range(99);
        if (r < 80) return lms_pkg::OP_TICK;
        if (r < 86) return lms_pkg::OP_APPEND;
        if (r < 89) return lms_pkg::OP_CLEAR;
        if (r < 92) return lms_pkg::OP_START;
        if (r < 95) return lms_pkg::OP_STOP;
        return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    task automatic send_word(logic [2:0] op, logic [lms_pkg::CHAR_W-1:0] ch);
        while (!quiet && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_char_code <= ch;
        do @(posedge i_clk); while (o_in_stall);
        advance_marquee(op, ch);
        words_sent++;
    endtask

    task automatic write_reg(logic [lms_pkg::CFG_INDEX_W-1:0] idx,
                             logic [lms_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_model_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the input channel until every predicted word is out, then let the pipe settle
    task automatic wait_idle();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (frames_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic check_field(string label, logic [lms_pkg::CHAR_W-1:0] want,
                               logic [lms_pkg::CHAR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frames_due.size() == 0) begin
                $display("%0t: result word expected none, got action %0d", $time, o_action);
                mismatches++;
            end else begin
                want = frames_due.pop_front();
                check_field("action", want.action, o_action);
                check_field("char_first", want.glyphs[0], o_char_first);
                check_field("char_second", want.glyphs[1], o_char_second);
                check_field("char_third", want.glyphs[2], o_char_third);
                check_field("char_fourth", want.glyphs[3], o_char_fourth);
                check_field("frame_color", want.color, o_frame_color);
                frames_checked++;
            end
        end
        i_out_stall <= !quiet && ($urandom_range(99) < 7);
    end

    task automatic test_idle_behaviour();
        send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_STOP, 8'hFF);
        send_word(OP_SPARE_LO, 8'h55);
        send_word(OP_SPARE_HI, 8'hAA);
        send_word(lms_pkg::OP_START, 8'h00);
        send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_TICK, 8'hFF);
        send_word(lms_pkg::OP_STOP, 8'h00);
        wait_idle();
    endtask

    task automatic test_forward_scroll();
        write_reg(lms_pkg::CFG_COLOR, 32'hFF);
        write_reg(lms_pkg::CFG_INTERVAL, '0);
        write_reg(lms_pkg::CFG_DIRECTION, '0);
        send_word(lms_pkg::OP_CLEAR, 8'h00);
        send_word(lms_pkg::OP_APPEND, 8'h00);
        send_word(lms_pkg::OP_APPEND, 8'hFF);
        send_word(lms_pkg::OP_START, 8'h00);
        repeat (8) send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_CLEAR, 8'h00);
        send_word(lms_pkg::OP_APPEND, 8'h7E);
        send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_STOP, 8'h00);
        wait_idle();
    endtask

    task automatic test_backward_scroll();
        write_reg(lms_pkg::CFG_COLOR, 32'h5A);
        write_reg(lms_pkg::CFG_INTERVAL, 32'd2);
        write_reg(lms_pkg::CFG_DIRECTION, 32'd1);
        send_word(lms_pkg::OP_START, 8'h00);
        repeat (14) send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_STOP, 8'h00);
        wait_idle();
        write_reg(lms_pkg::CFG_INTERVAL, INTERVAL_MAX);
        send_word(lms_pkg::OP_START, 8'h00);
        repeat (3) send_word(lms_pkg::OP_TICK, 8'h00);
        send_word(lms_pkg::OP_STOP, 8'h00);
        wait_idle();
    endtask

    // no idling here: back-to-back words through a full store and a whole wrap
    task automatic test_full_text();
        quiet = 1'b1;
        write_reg(lms_pkg::CFG_INTERVAL, '0);
        write_reg(lms_pkg::CFG_DIRECTION, '0);
        send_word(lms_pkg::OP_CLEAR, 8'($urandom));
        repeat (TEXT_CAP + 4) send_word(lms_pkg::OP_APPEND, 8'($urandom));
        send_word(lms_pkg::OP_START, 8'($urandom));
        repeat (TEXT_CAP + lms_pkg::WINDOW_W + 2) send_word(lms_pkg::OP_TICK, 8'($urandom));
        send_word(lms_pkg::OP_STOP, 8'($urandom));
        wait_idle();
        quiet = 1'b0;
    endtask

    task automatic pick_registers();
        int unsigned r;
        r = $urandom_range(99);
        write_reg(lms_pkg::CFG_COLOR, $urandom);
        if (r < 5)
            write_reg(lms_pkg::CFG_INTERVAL, INTERVAL_MAX);
        else if (r < 15)
            write_reg(lms_pkg::CFG_INTERVAL, $urandom_range(4, 9));
        else
            write_reg(lms_pkg::CFG_INTERVAL, $urandom_range(0, 3));
        write_reg(lms_pkg::CFG_DIRECTION, $urandom);
        if ($urandom_range(9) == 0)
            write_reg(CFG_SPARE, $urandom);
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned len;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            wait_idle();
            pick_registers();
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(3) != 0) begin
                    send_word(lms_pkg::OP_CLEAR, 8'($urandom));
                    len = ($urandom_range(9) == 0) ? $urandom_range(20, TEXT_CAP + 2)
                                                   : $urandom_range(0, 8);
                    repeat (len) send_word(lms_pkg::OP_APPEND, 8'($urandom));
                end
                send_word(lms_pkg::OP_START, 8'($urandom));
                repeat ($urandom_range(10, 40)) send_word(scroll_op(), 8'($urandom));
                if ($urandom_range(9) < 7)
                    send_word(lms_pkg::OP_STOP, 8'($urandom));
            end else begin
                repeat ($urandom_range(5, 20))
                    send_word(3'($urandom_range(lms_pkg::OP_CLEAR, OP_SPARE_HI)),
                              8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_behaviour();
        test_forward_scroll();
        test_backward_scroll();
        test_full_text();
        test_random_traffic();
        wait_idle();
        if (frames_due.size() != 0)
            $display("%0t: %0d expected result words never arrived", $time, frames_due.size());
        $display("Run: %0d input words, %0d result words checked, %0d register writes.",
                 words_sent, frames_checked, reg_writes);
        $display("Covered both scroll directions with wrap, full store and live register changes.");
        if (mismatches == 0 && frames_due.size() == 0)
            $display("** led_text_marquee_scroller_top: PASSED **");
        else
            $display("** led_text_marquee_scroller_top: FAILED **");
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: run timed out", $time);
        $display("** led_text_marquee_scroller_top: FAILED **");
        $finish;
    end

endmodule
